// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker module of the record deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BFRD_ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Concurrent assertion on the block clock and reset.
`define BFRD_ASSERT(name, prop) `BFRD_ASSERT_CLK(name, aclk, aresetn, prop)

`endif

// ----- src/bfrd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfrd_pkg
// Types, constants and register map of the block file record deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bfrd_pkg;

    // Field widths.
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned CLASS_W   = 3;
    localparam int unsigned TUSER_W   = 6;
    localparam int unsigned LEN_W     = 32;
    localparam int unsigned REM_W     = 32;
    localparam int unsigned TRAILER_W = 8;
    localparam int unsigned NUM_MAGIC = 3;

    // Configuration port.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_UNDO_MODE = 3'd0;

    // Default trailer length of undo records.
    localparam int unsigned TRAILER_BYTES_DEFAULT = 32;

    // Network magics, first stream byte in the lowest bits.
    localparam logic [31:0] MAGIC_WORDS [NUM_MAGIC] = '{
        32'hd9b4bef9,
        32'h0709110b,
        32'hdab5bffa
    };

    // Framer phase, one-hot.
    typedef enum logic [4:0] {
        PH_MAGIC    = 5'b00001,
        PH_LENGTH   = 5'b00010,
        PH_PAYLOAD  = 5'b00100,
        PH_TRAILER  = 5'b01000,
        PH_UNFRAMED = 5'b10000
    } phase_t;

    // Byte class reported with every byte.
    typedef enum logic [CLASS_W-1:0] {
        CLS_MAGIC    = 3'd0,
        CLS_LENGTH   = 3'd1,
        CLS_PAYLOAD  = 3'd2,
        CLS_TRAILER  = 3'd3,
        CLS_UNFRAMED = 3'd4
    } byte_class_t;

    // One input byte.
    typedef struct packed {
        logic              end_of_data;
        logic [DATA_W-1:0] data_byte;
    } item_t;

    // One tagged output byte.
    typedef struct packed {
        logic              record_incomplete;
        logic              bad_magic;
        logic              record_last;
        logic              record_first;
        byte_class_t       byte_class;
        logic [DATA_W-1:0] byte_out;
    } result_t;

endpackage

`default_nettype wire

// ----- src/bfrd_cfg.sv -----
// ----------------------------------------------------------------------------
// bfrd_cfg
// APB register file holding the undo file mode bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bfrd_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bfrd_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [bfrd_pkg::PDATA_W-1:0]     pwdata,
    output logic      [bfrd_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready,
    output logic                                  undo_mode
);

    logic undo_mode_reg;
    logic undo_mode_next;
    logic wr_en;

    // Zero wait states.
    assign pready = 1'b1;

    // Register write in the access phase.
    assign wr_en = psel && penable && pwrite && pready &&
                   (paddr == bfrd_pkg::ADDR_UNDO_MODE);

    always_comb begin
        undo_mode_next = undo_mode_reg;
        if (wr_en) begin
            undo_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            undo_mode_reg <= 1'b0;
        end else begin
            undo_mode_reg <= undo_mode_next;
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr == bfrd_pkg::ADDR_UNDO_MODE) begin
            prdata[0] = undo_mode_reg;
        end
    end

    assign undo_mode = undo_mode_reg;

endmodule

`default_nettype wire

// ----- src/bfrd_frame.sv -----
// ----------------------------------------------------------------------------
// bfrd_frame
// Framing state and per-byte tagging logic of the record deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module bfrd_frame #(
    parameter int unsigned TRAILER_BYTES = bfrd_pkg::TRAILER_BYTES_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire bfrd_pkg::item_t   item,
    input  wire logic              undo_mode,
    output bfrd_pkg::result_t      result
);

    localparam logic [bfrd_pkg::TRAILER_W-1:0] TRAILER_LEN =
        bfrd_pkg::TRAILER_W'(TRAILER_BYTES % 256);
    localparam bit HAS_TRAILER = (TRAILER_LEN != '0);

    bfrd_pkg::phase_t                 phase_reg,  phase_next;
    logic [1:0]                       idx_reg,    idx_next;
    logic [bfrd_pkg::NUM_MAGIC-1:0]   cand_reg,   cand_next;
    logic [bfrd_pkg::LEN_W-1:0]       len_reg,    len_next;
    logic [bfrd_pkg::REM_W-1:0]       rem_reg,    rem_next;

    logic [bfrd_pkg::NUM_MAGIC-1:0]   magic_hit;
    logic [bfrd_pkg::LEN_W-1:0]       len_merged;
    logic [bfrd_pkg::REM_W-1:0]       rem_dec;
    logic                             payload_done;

    // Which magics agree with this byte at the current header position.
    always_comb begin
        for (int k = 0; k < bfrd_pkg::NUM_MAGIC; k++) begin
            magic_hit[k] = (bfrd_pkg::MAGIC_WORDS[k][8*idx_reg +: 8] == item.data_byte);
        end
    end

    // Length byte merged into the little-endian accumulator.
    always_comb begin
        len_merged = len_reg;
        len_merged[8*idx_reg +: 8] = len_reg[8*idx_reg +: 8] | item.data_byte;
    end

    // Saturating count-down of the remaining bytes.
    assign rem_dec = rem_reg - bfrd_pkg::REM_W'(rem_reg != '0);

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        cand_next    = cand_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        payload_done = 1'b0;

        result.byte_out          = item.data_byte;
        result.byte_class        = bfrd_pkg::CLS_UNFRAMED;
        result.record_first      = 1'b0;
        result.record_last       = 1'b0;
        result.bad_magic         = 1'b0;
        result.record_incomplete = 1'b0;

        // Phase step for this byte.
        unique case (phase_reg)
            bfrd_pkg::PH_MAGIC: begin
                result.byte_class   = bfrd_pkg::CLS_MAGIC;
                result.record_first = (idx_reg == 2'd0);
                cand_next           = cand_reg & magic_hit;
                if (idx_reg == 2'd3) begin
                    idx_next = 2'd0;
                    if (cand_next == '0) begin
                        result.bad_magic = 1'b1;
                        phase_next       = bfrd_pkg::PH_UNFRAMED;
                    end else begin
                        phase_next = bfrd_pkg::PH_LENGTH;
                        len_next   = '0;
                    end
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            bfrd_pkg::PH_LENGTH: begin
                result.byte_class = bfrd_pkg::CLS_LENGTH;
                len_next          = len_merged;
                if (idx_reg == 2'd3) begin
                    idx_next = 2'd0;
                    if (len_merged == '0) begin
                        payload_done = 1'b1;
                    end else begin
                        phase_next = bfrd_pkg::PH_PAYLOAD;
                        rem_next   = len_merged;
                    end
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            bfrd_pkg::PH_PAYLOAD: begin
                result.byte_class = bfrd_pkg::CLS_PAYLOAD;
                rem_next          = rem_dec;
                payload_done      = (rem_dec == '0);
            end
            bfrd_pkg::PH_TRAILER: begin
                result.byte_class = bfrd_pkg::CLS_TRAILER;
                rem_next          = rem_dec;
                if (rem_dec == '0) begin
                    result.record_last = 1'b1;
                    phase_next         = bfrd_pkg::PH_MAGIC;
                    idx_next           = 2'd0;
                    cand_next          = '1;
                    len_next           = '0;
                    rem_next           = '0;
                end
            end
            bfrd_pkg::PH_UNFRAMED: begin
                phase_next = bfrd_pkg::PH_UNFRAMED;
            end
            default: begin
                phase_next = bfrd_pkg::PH_UNFRAMED;
            end
        endcase

        // End of payload: open the trailer or close the record.
        if (payload_done) begin
            if (undo_mode && HAS_TRAILER) begin
                phase_next = bfrd_pkg::PH_TRAILER;
                rem_next   = bfrd_pkg::REM_W'(TRAILER_LEN);
            end else begin
                result.record_last = 1'b1;
                phase_next         = bfrd_pkg::PH_MAGIC;
                idx_next           = 2'd0;
                cand_next          = '1;
                len_next           = '0;
                rem_next           = '0;
            end
        end

        // End of data inside an open record: flag it and rearm.
        if (item.end_of_data && (phase_next != bfrd_pkg::PH_UNFRAMED) &&
            !((phase_next == bfrd_pkg::PH_MAGIC) && (idx_next == 2'd0))) begin
            result.record_incomplete = 1'b1;
            phase_next               = bfrd_pkg::PH_MAGIC;
            idx_next                 = 2'd0;
            cand_next                = '1;
            len_next                 = '0;
            rem_next                 = '0;
        end
    end

    // State advances once per byte handed to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bfrd_pkg::PH_MAGIC;
            idx_reg   <= 2'd0;
            cand_reg  <= '1;
            len_reg   <= '0;
            rem_reg   <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/block_file_record_deframer_top.sv -----
// ----------------------------------------------------------------------------
// block_file_record_deframer_top
// Tags each byte of a stored record stream with its class and record marks.
// Result path: input register, framing step, result register; registered output.
// Throughput: 1 byte per cycle while the result stream does not stall, set by the
// input register, the combinational framing step and the result register.
// Reset: synchronous, active low; framer rearms, error and mode bit clear.
// ----------------------------------------------------------------------------
`default_nettype none

module block_file_record_deframer_top #(
    parameter int unsigned TRAILER_BYTES = bfrd_pkg::TRAILER_BYTES_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bfrd_pkg::DATA_W-1:0]       s_tdata,  // [7:0] data_byte
    input  wire logic                              s_tlast,  // end_of_data
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [bfrd_pkg::DATA_W-1:0]       m_tdata,  // [7:0] byte_out
    output logic      [bfrd_pkg::TUSER_W-1:0]      m_tuser,  // [2:0] byte_class,
                                                             // [3] record_first,
                                                             // [4] bad_magic,
                                                             // [5] record_incomplete
    output logic                                   m_tlast,  // record_last
    // Configuration port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bfrd_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [bfrd_pkg::PDATA_W-1:0]      pwdata,
    output logic      [bfrd_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);

    logic               in_valid_reg,  in_valid_next;
    bfrd_pkg::item_t    in_item_reg;
    logic               out_valid_reg, out_valid_next;
    bfrd_pkg::result_t  out_res_reg;
    bfrd_pkg::result_t  result;
    logic               advance;
    logic               in_take;
    logic               undo_mode;

    // Configuration registers.
    bfrd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .undo_mode (undo_mode)
    );

    // A byte moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.data_byte   <= s_tdata;
            in_item_reg.end_of_data <= s_tlast;
        end
    end

    // Framing step.
    bfrd_frame #(
        .TRAILER_BYTES (TRAILER_BYTES)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (in_item_reg),
        .undo_mode (undo_mode),
        .result    (result)
    );

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    // Result stream outputs.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.byte_out;
    assign m_tuser  = {out_res_reg.record_incomplete, out_res_reg.bad_magic,
                       out_res_reg.record_first, out_res_reg.byte_class};
    assign m_tlast  = out_res_reg.record_last;

endmodule

`default_nettype wire

// ----- src/bfrd_checker.sv -----
// ----------------------------------------------------------------------------
// bfrd_checker
// Port-level checks of the record deframer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bfrd_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bfrd_pkg::DATA_W-1:0]      m_tdata,
    input wire logic [bfrd_pkg::TUSER_W-1:0]     m_tuser,
    input wire logic                             m_tlast
);

    logic [bfrd_pkg::CLASS_W-1:0] cls;
    logic                         first;
    logic                         bad;
    logic                         incomplete;

    assign cls        = m_tuser[2:0];
    assign first      = m_tuser[3];
    assign bad        = m_tuser[4];
    assign incomplete = m_tuser[5];

    // An unframed byte carries no record marks.
    `BFRD_ASSERT(a_unframed_quiet, m_tvalid && (cls == bfrd_pkg::CLS_UNFRAMED) |-> !m_tlast && !first && !bad && !incomplete)

    // A bad magic is reported on a magic byte that neither opens nor closes a record.
    `BFRD_ASSERT(a_bad_on_magic, m_tvalid && bad |-> (cls == bfrd_pkg::CLS_MAGIC) && !first && !m_tlast)

    // The first byte of a record is a magic byte and cannot close it.
    `BFRD_ASSERT(a_first_on_magic, m_tvalid && first |-> (cls == bfrd_pkg::CLS_MAGIC) && !m_tlast)

    // After a bad magic every following byte stays unframed.
    `BFRD_ASSERT(a_sticky_error, m_tvalid && m_tready && (bad || (cls == bfrd_pkg::CLS_UNFRAMED)) |=> !m_tvalid || (cls == bfrd_pkg::CLS_UNFRAMED))

    // A stalled result holds its payload.
    `BFRD_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind block_file_record_deframer_top bfrd_checker u_bfrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
